@@ src/lmps_pkg.sv @@
// Package with the request codes, state type and constants of the LED matrix PWM scanner.
`timescale 1ns / 1ps

package lmps_pkg;

    typedef enum logic [2:0] {
        REQ_SCAN     = 3'd0,
        REQ_PIXEL    = 3'd1,
        REQ_CLEAR    = 3'd2,
        REQ_ALL_HIGH = 3'd3,
        REQ_RECT     = 3'd4,
        REQ_COL_WORD = 3'd5
    } t_req_type;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SCAN
    } t_state;

    localparam logic [15:0] ALL_HIGH_WORD = 16'hFFFC;

    localparam logic [1:0] PWM_THR [4] = '{2'd3, 2'd3, 2'd2, 2'd1};

endpackage

@@ src/led_matrix_pwm_scanner_unit.sv @@
// Top level of the LED matrix PWM scanner: frame memory, column walker and scan output.
// A scan tick word reads its column into the read register, then the scan state loads the result.
// An edit word reads and writes back each column that it covers; one that writes nothing stays idle.
// One word is in work at a time.
// While the result register waits, edit words still go in; a scan tick holds in the scan state.
// After reset a clearing pass writes zero to every column, with ready low until it ends.
`timescale 1ns / 1ps

module led_matrix_pwm_scanner_unit #(
    parameter int ROW_COUNT = 7,
    parameter int COL_COUNT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_row_first,
    input  logic [3:0]  i_row_last,
    input  logic [3:0]  i_col_first,
    input  logic [3:0]  i_col_last,
    input  logic [1:0]  i_luminosity,
    input  logic [15:0] i_health_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_scan_column,
    output logic [4:0]  o_column_drive_n,
    output logic [6:0]  o_row_drive_n,
    output logic [1:0]  o_pwm_phase
);
    import lmps_pkg::*;

    localparam int            CW       = $clog2(COL_COUNT);
    localparam logic [CW-1:0] COL_LAST = CW'(COL_COUNT - 1);
    localparam logic [3:0]    ROW_LIM  = 4'(ROW_COUNT);
    localparam logic [3:0]    COL_LIM  = 4'(COL_COUNT);

    function automatic logic [15:0] row_mask(input logic [3:0] lo, input logic [3:0] hi);
        logic [15:0] m;
        m = '0;
        for (int r = 1; r <= 7; r++) begin
            m[2*r +: 2] = ((4'(r) >= lo) && (4'(r) <= hi)) ? 2'b11 : 2'b00;
        end
        return m;
    endfunction

    logic [15:0]   r_frame [COL_COUNT];
    logic [15:0]   r_rd_data;

    t_state        r_state, n_state;
    logic [CW-1:0] r_rd_col, n_rd_col;
    logic          r_rd_more, n_rd_more;
    logic [CW-1:0] r_col_hi, n_col_hi;
    logic [CW-1:0] r_wr_col, n_wr_col;
    logic          r_wr_vld, n_wr_vld;
    logic [15:0]   r_mask, n_mask;
    logic [15:0]   r_pat, n_pat;
    logic [CW-1:0] r_next_col, n_next_col;
    logic [CW-1:0] r_scan_col, n_scan_col;
    logic [1:0]    r_phase, n_phase;

    logic          r_out_vld, n_out_vld;
    logic [2:0]    r_out_col, n_out_col;
    logic [4:0]    r_out_cols_n, n_out_cols_n;
    logic [6:0]    r_out_rows_n, n_out_rows_n;
    logic [1:0]    r_out_phase, n_out_phase;

    logic          accept;
    logic          dec_walk;
    logic          dec_scan;
    logic [CW-1:0] dec_lo, dec_hi;
    logic [15:0]   dec_mask, dec_pat;
    logic [3:0]    rect_r0, rect_r1, rect_c0, rect_c1;

    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic          wr_en;
    logic [15:0]   wr_data;
    logic          load_out;
    logic [1:0]    thr;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign rect_r0 = (i_row_first == 4'd0) ? 4'd1 : i_row_first;
    assign rect_r1 = (i_row_last > ROW_LIM) ? ROW_LIM : i_row_last;
    assign rect_c0 = (i_col_first == 4'd0) ? 4'd1 : i_col_first;
    assign rect_c1 = (i_col_last > COL_LIM) ? COL_LIM : i_col_last;

    always_comb begin
        dec_walk = 1'b0;
        dec_scan = 1'b0;
        dec_lo   = '0;
        dec_hi   = COL_LAST;
        dec_mask = '1;
        dec_pat  = '0;
        case (t_req_type'(i_req_type))
            REQ_SCAN: begin
                dec_scan = 1'b1;
            end
            REQ_PIXEL: begin
                dec_walk = (i_row_first >= 4'd1) && (i_row_first <= ROW_LIM)
                        && (i_col_first >= 4'd1) && (i_col_first <= COL_LIM);
                dec_lo   = CW'(i_col_first - 4'd1);
                dec_hi   = CW'(i_col_first - 4'd1);
                dec_mask = row_mask(i_row_first, i_row_first);
                dec_pat  = {8{i_luminosity}};
            end
            REQ_CLEAR: begin
                dec_walk = 1'b1;
            end
            REQ_ALL_HIGH: begin
                dec_walk = 1'b1;
                dec_pat  = ALL_HIGH_WORD;
            end
            REQ_RECT: begin
                dec_walk = (rect_r0 <= rect_r1) && (rect_c0 <= rect_c1);
                dec_lo   = CW'(rect_c0 - 4'd1);
                dec_hi   = CW'(rect_c1 - 4'd1);
                dec_mask = row_mask(rect_r0, rect_r1);
                dec_pat  = {8{i_luminosity}};
            end
            REQ_COL_WORD: begin
                dec_walk = 1'b1;
                dec_lo   = COL_LAST;
                dec_pat  = i_health_word;
            end
            default: begin
                dec_walk = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && dec_walk) begin
                    n_state = S_WALK;
                end else if (accept && dec_scan) begin
                    n_state = S_SCAN;
                end
            end
            S_WALK: begin
                if (!r_rd_more && r_wr_vld) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!r_out_vld || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_en        = 1'b0;
        rd_addr      = r_rd_col;
        wr_en        = 1'b0;
        wr_data      = (r_rd_data & ~r_mask) | (r_pat & r_mask);
        load_out     = 1'b0;
        n_rd_col     = r_rd_col;
        n_rd_more    = r_rd_more;
        n_col_hi     = r_col_hi;
        n_wr_col     = r_wr_col;
        n_wr_vld     = 1'b0;
        n_mask       = r_mask;
        n_pat        = r_pat;
        n_next_col   = r_next_col;
        n_scan_col   = r_scan_col;
        n_phase      = r_phase;
        thr          = PWM_THR[r_phase];
        n_out_col    = r_out_col;
        n_out_cols_n = r_out_cols_n;
        n_out_rows_n = r_out_rows_n;
        n_out_phase  = r_out_phase;
        case (r_state)
            S_IDLE: begin
                if (accept && dec_walk) begin
                    n_rd_col  = dec_lo;
                    n_rd_more = 1'b1;
                    n_col_hi  = dec_hi;
                    n_mask    = dec_mask;
                    n_pat     = dec_pat;
                end else if (accept && dec_scan) begin
                    rd_en      = 1'b1;
                    rd_addr    = r_next_col;
                    n_scan_col = r_next_col;
                    n_next_col = (r_next_col == COL_LAST) ? '0 : CW'(r_next_col + 1'b1);
                    if (r_next_col == '0) begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            S_WALK: begin
                rd_en    = r_rd_more;
                wr_en    = r_wr_vld;
                n_wr_vld = r_rd_more;
                n_wr_col = r_rd_col;
                if (r_rd_more) begin
                    n_rd_more = (r_rd_col != r_col_hi);
                    n_rd_col  = CW'(r_rd_col + 1'b1);
                end
            end
            S_SCAN: begin
                load_out  = !r_out_vld || i_ready;
                n_out_col = 3'({1'b0, r_scan_col} + 1'b1);
                for (int j = 0; j < 5; j++) begin
                    n_out_cols_n[j] = (j < COL_COUNT) && (j != int'(r_scan_col));
                end
                for (int i = 1; i <= 7; i++) begin
                    n_out_rows_n[i-1] = (i <= ROW_COUNT) && (r_rd_data[2*i +: 2] < thr);
                end
                n_out_phase = r_phase;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
        n_out_vld = load_out || (r_out_vld && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frame[r_wr_col] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_frame[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_WALK;
            r_rd_col   <= '0;
            r_rd_more  <= 1'b1;
            r_col_hi   <= COL_LAST;
            r_wr_vld   <= 1'b0;
            r_mask     <= '1;
            r_pat      <= '0;
            r_next_col <= '0;
            r_phase    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_col   <= n_rd_col;
            r_rd_more  <= n_rd_more;
            r_col_hi   <= n_col_hi;
            r_wr_vld   <= n_wr_vld;
            r_mask     <= n_mask;
            r_pat      <= n_pat;
            r_next_col <= n_next_col;
            r_phase    <= n_phase;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_col   <= n_wr_col;
        r_scan_col <= n_scan_col;
        if (load_out) begin
            r_out_col    <= n_out_col;
            r_out_cols_n <= n_out_cols_n;
            r_out_rows_n <= n_out_rows_n;
            r_out_phase  <= n_out_phase;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_scan_column    = r_out_col;
    assign o_column_drive_n = r_out_cols_n;
    assign o_row_drive_n    = r_out_rows_n;
    assign o_pwm_phase      = r_out_phase;

    // The column pointer never leaves the matrix.
    a_next_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_col <= COL_LAST)
        else $error("scan column pointer out of range");

    // The walker never reads the column that it writes in the same cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != r_wr_col))
        else $error("frame read and write hit the same column");

    // A new result word only ever comes from the scan state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_SCAN))
        else $error("result raised outside the scan state");

    // The PWM phase moves only when a scan tick starts on the first column.
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != $past(r_phase)) |-> $past(accept && dec_scan && (r_next_col == '0)))
        else $error("PWM phase changed without a first-column scan");

endmodule

@@ verif/tb_led_matrix_pwm_scanner_unit.sv @@
// Self-checking testbench for the LED matrix PWM scanner with frame edits and scan ticks.
`timescale 1ns / 1ps

module tb_led_matrix_pwm_scanner_unit;

    import lmps_pkg::*;

    localparam int ROW_N = 7;
    localparam int COL_N = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]  req;
        logic [3:0]  row_first;
        logic [3:0]  row_last;
        logic [3:0]  col_first;
        logic [3:0]  col_last;
        logic [1:0]  lum;
        logic [15:0] health;
    } t_request;

    typedef struct {
        logic [2:0] column;
        logic [4:0] column_n;
        logic [6:0] rows_n;
        logic [1:0] phase;
    } t_scan_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_req_type;
    logic [3:0]  i_row_first;
    logic [3:0]  i_row_last;
    logic [3:0]  i_col_first;
    logic [3:0]  i_col_last;
    logic [1:0]  i_luminosity;
    logic [15:0] i_health_word;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_scan_column;
    logic [4:0]  o_column_drive_n;
    logic [6:0]  o_row_drive_n;
    logic [1:0]  o_pwm_phase;

    logic [15:0]  frame_words [COL_N];
    logic [1:0]   pwm_step;
    int           scan_next;
    t_scan_result pending_scans [$];
    t_scan_result oldest_scan;
    int           mismatch_count = 0;
    bit           steady = 1'b0;
    int           rx_hold = 0;

    led_matrix_pwm_scanner_unit #(
        .ROW_COUNT(ROW_N),
        .COL_COUNT(COL_N)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_row_first     (i_row_first),
        .i_row_last      (i_row_last),
        .i_col_first     (i_col_first),
        .i_col_last      (i_col_last),
        .i_luminosity    (i_luminosity),
        .i_health_word   (i_health_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_scan_column   (o_scan_column),
        .o_column_drive_n(o_column_drive_n),
        .o_row_drive_n   (o_row_drive_n),
        .o_pwm_phase     (o_pwm_phase)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void paint_pixel(int row, int col, logic [1:0] lum);
        if (row < 1 || row > ROW_N || col < 1 || col > COL_N) return;
        frame_words[col - 1][2 * row +: 2] = lum;
    endfunction

    function automatic void apply_request(t_request w);
        int col;
        int r_lo;
        int r_hi;
        int c_lo;
        int c_hi;
        logic [1:0] thr;
        t_scan_result res;
        case (w.req)
            REQ_SCAN: begin
                col = scan_next;
                if (col < 1 || col > COL_N) col = 1;
                if (col == 1) pwm_step = pwm_step + 2'd1;
                thr = PWM_THR[pwm_step];
                for (int r = 1; r <= ROW_N; r++) begin
                    res.rows_n[r - 1] = frame_words[col - 1][2 * r +: 2] < thr;
                end
                res.column = col[2:0];
                res.column_n = ~(5'b00001 << (col - 1));
                res.phase = pwm_step;
                pending_scans.push_back(res);
                scan_next = (col < COL_N) ? col + 1 : 1;
            end
            REQ_PIXEL: paint_pixel(int'(w.row_first), int'(w.col_first), w.lum);
            REQ_CLEAR: begin
                for (int c = 0; c < COL_N; c++) frame_words[c] = '0;
            end
            REQ_ALL_HIGH: begin
                for (int c = 0; c < COL_N; c++) frame_words[c] = ALL_HIGH_WORD;
            end
            REQ_RECT: begin
                r_lo = (w.row_first < 4'd1) ? 1 : int'(w.row_first);
                r_hi = (int'(w.row_last) > ROW_N) ? ROW_N : int'(w.row_last);
                c_lo = (w.col_first < 4'd1) ? 1 : int'(w.col_first);
                c_hi = (int'(w.col_last) > COL_N) ? COL_N : int'(w.col_last);
                for (int r = r_lo; r <= r_hi; r++) begin
                    for (int c = c_lo; c <= c_hi; c++) paint_pixel(r, c, w.lum);
                end
            end
            REQ_COL_WORD: frame_words[COL_N - 1] = w.health;
            default: ;
        endcase
    endfunction

    function automatic t_request make_request(logic [2:0] req, int rf, int rl, int cf, int cl,
                                              int lum, int health);
        t_request w;
        w.req = req;
        w.row_first = 4'(rf);
        w.row_last = 4'(rl);
        w.col_first = 4'(cf);
        w.col_last = 4'(cl);
        w.lum = 2'(lum);
        w.health = 16'(health);
        return w;
    endfunction

    function automatic t_request random_request();
        t_request w;
        int pick;
        w = make_request(REQ_SCAN, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 3), $urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            w.req = REQ_SCAN;
        end else if (pick < 62) begin
            w.req = REQ_PIXEL;
            if ($urandom_range(0, 9) < 8) begin
                w.row_first = 4'($urandom_range(1, ROW_N));
                w.col_first = 4'($urandom_range(1, COL_N));
            end
        end else if (pick < 66) begin
            w.req = REQ_CLEAR;
        end else if (pick < 70) begin
            w.req = REQ_ALL_HIGH;
        end else if (pick < 88) begin
            w.req = REQ_RECT;
            if ($urandom_range(0, 9) < 7) begin
                w.row_first = 4'($urandom_range(0, ROW_N + 1));
                w.row_last = 4'($urandom_range(0, ROW_N + 1));
                w.col_first = 4'($urandom_range(0, COL_N + 1));
                w.col_last = 4'($urandom_range(0, COL_N + 1));
            end
        end else if (pick < 96) begin
            w.req = REQ_COL_WORD;
        end else begin
            w.req = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
        end
        return w;
    endfunction

    task automatic offer_request(input t_request w);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type <= w.req;
        i_row_first <= w.row_first;
        i_row_last <= w.row_last;
        i_col_first <= w.col_first;
        i_col_last <= w.col_last;
        i_luminosity <= w.lum;
        i_health_word <= w.health;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        apply_request(w);
    endtask

    task automatic scan_ticks(input int count);
        t_request w;
        repeat (count) begin
            w = random_request();
            w.req = REQ_SCAN;
            offer_request(w);
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_scans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_scan_walk();
        scan_ticks(5);
        wait_for_results();
    endtask

    task automatic test_pixel_limits();
        offer_request(make_request(REQ_PIXEL, 1, 0, 1, 0, 3, 0));
        offer_request(make_request(REQ_PIXEL, ROW_N, 0, COL_N, 0, 2, 0));
        offer_request(make_request(REQ_PIXEL, 0, 0, 1, 0, 1, 0));
        offer_request(make_request(REQ_PIXEL, ROW_N + 1, 0, 1, 0, 1, 0));
        offer_request(make_request(REQ_PIXEL, 1, 0, 0, 0, 1, 0));
        offer_request(make_request(REQ_PIXEL, 15, 0, 15, 0, 1, 0));
        scan_ticks(5);
        wait_for_results();
    endtask

    task automatic test_frame_fills();
        offer_request(make_request(REQ_ALL_HIGH, 0, 0, 0, 0, 0, 0));
        scan_ticks(1);
        offer_request(make_request(REQ_COL_WORD, 0, 0, 0, 0, 0, 16'hFFFF));
        offer_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        offer_request(make_request(REQ_RECT, 0, 15, 0, 15, 2, 0));
        scan_ticks(2);
        offer_request(make_request(REQ_RECT, 6, 2, 1, COL_N, 3, 0));
        offer_request(make_request(REQ_RECT, 1, ROW_N, 4, 3, 3, 0));
        offer_request(make_request(REQ_RECT, 3, 4, 2, 3, 1, 0));
        offer_request(make_request(REQ_COL_WORD, 0, 0, 0, 0, 0, 16'h0003));
        offer_request(make_request(REQ_SPARE_LO, 1, 1, 1, 1, 3, 16'hFFFF));
        offer_request(make_request(REQ_SPARE_HI, 1, 1, 1, 1, 3, 16'hFFFF));
        scan_ticks(2);
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        rx_hold = 200;
        repeat (40) offer_request(random_request());
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (150) offer_request(random_request());
        steady = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_mix();
        repeat (8) begin
            repeat ($urandom_range(85, 125)) offer_request(random_request());
            wait_for_results();
        end
    endtask

    initial begin
        int stall;
        stall = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if (steady) begin
                i_ready <= 1'b1;
            end else if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else if ($urandom_range(0, 99) < 25) begin
                stall = pick_gap();
                i_ready <= (stall == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_scans.size() == 0) begin
                report_mismatch("scan result with none pending", int'(o_scan_column), 0);
            end else begin
                oldest_scan = pending_scans.pop_front();
                if (o_scan_column !== oldest_scan.column)
                    report_mismatch("scan_column", int'(o_scan_column),
                                    int'(oldest_scan.column));
                if (o_column_drive_n !== oldest_scan.column_n)
                    report_mismatch("column_drive_n", int'(o_column_drive_n),
                                    int'(oldest_scan.column_n));
                if (o_row_drive_n !== oldest_scan.rows_n)
                    report_mismatch("row_drive_n", int'(o_row_drive_n),
                                    int'(oldest_scan.rows_n));
                if (o_pwm_phase !== oldest_scan.phase)
                    report_mismatch("pwm_phase", int'(o_pwm_phase), int'(oldest_scan.phase));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("led_matrix_pwm_scanner_unit: mismatch");
        $finish;
    end

    initial begin
        for (int c = 0; c < COL_N; c++) frame_words[c] = '0;
        pwm_step = '0;
        scan_next = 1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = REQ_SCAN;
        i_row_first = '0;
        i_row_last = '0;
        i_col_first = '0;
        i_col_last = '0;
        i_luminosity = '0;
        i_health_word = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_scan_walk();
        test_pixel_limits();
        test_frame_fills();
        test_output_backpressure();
        test_back_to_back();
        test_random_mix();

        if (pending_scans.size() != 0)
            report_mismatch("scan results never produced", 0, pending_scans.size());
        if (mismatch_count == 0) begin
            $display("led_matrix_pwm_scanner_unit: match");
        end else begin
            $display("led_matrix_pwm_scanner_unit: mismatch");
        end
        $finish;
    end

endmodule
